/* rtl/srsw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat sender window
// Field widths, event and result codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int CMD_W       = 2;
  localparam int FRAME_NUM_W = 10;
  localparam int KIND_W      = 2;
  localparam int FRAME_W     = 11;
  localparam int TIMER_W     = 16;
  localparam int RETRY_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int WINDOW_DEF     = 4;
  localparam int MAX_FRAMES_DEF = 1024;

  localparam logic [TIMER_W-1:0] TIMEOUT_RST     = TIMER_W'(2000);
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = RETRY_W'(3);
  localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = FRAME_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ACK   = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    K_SEND   = 2'd0,
    K_RESEND = 2'd1,
    K_DONE   = 2'd2,
    K_ABORT  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT     = 2'd0,
    CFG_RETRY_LIMIT = 2'd1,
    CFG_FRAME_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TIMER_W-1:0] reload;
    logic [RETRY_W-1:0] retry_limit;
    logic [FRAME_W-1:0] live_count;
  } cfg_t;

endpackage

/* rtl/srsw_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw channel interfaces
// Event input, result output and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface srsw_evt_if;
  import srsw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [FRAME_NUM_W-1:0] ack_frame;
  modport source (output valid, cmd, ack_frame, input ready);
  modport sink   (input valid, cmd, ack_frame, output ready);
endinterface

interface srsw_res_if;
  import srsw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [FRAME_NUM_W-1:0] tx_frame;
  logic                   last;
  modport source (output valid, kind, tx_frame, last, input ready);
  modport sink   (input valid, kind, tx_frame, last, output ready);
endinterface

interface srsw_cfg_if;
  import srsw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

/* rtl/srsw_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_cfg: configuration registers
// Holds timeout, retry limit and frame count; presents the effective values.
// ----------------------------------------------------------------------------
module srsw_cfg #(
  parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  srsw_cfg_if.sink          cfg_i,
  output srsw_pkg::cfg_t    cfg_o
);
  import srsw_pkg::*;

  localparam int FC_MAX = (1 << FRAME_W) - 1;
  localparam int SAT_I  = (MAX_FRAMES > FC_MAX) ? FC_MAX : MAX_FRAMES;
  localparam logic [FRAME_W-1:0] SAT = FRAME_W'(SAT_I);

  logic [TIMER_W-1:0] timeout_q;
  logic [RETRY_W-1:0] retry_limit_q;
  logic [FRAME_W-1:0] frame_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_TIMEOUT:     timeout_q     <= cfg_i.data[TIMER_W-1:0];
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_i.data[RETRY_W-1:0];
        CFG_FRAME_COUNT: frame_count_q <= cfg_i.data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // zero timeout behaves as one tick; frame count clamps to the frame space
  assign cfg_o.reload      = (timeout_q == '0) ? TIMER_W'(1) : timeout_q;
  assign cfg_o.retry_limit = retry_limit_q;
  assign cfg_o.live_count  = (frame_count_q > SAT) ? SAT : frame_count_q;

endmodule

/* rtl/selective_repeat_sender_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit: selective-repeat ARQ sender window
// Start, timer tick and ack events drive send, resend, complete and abort
// transactions; a small sequencer visits one window slot per cycle unless results stall.
// ----------------------------------------------------------------------------
//  channel  dir  payload                       transaction when
//  evt_i    in   cmd, ack_frame                valid && ready
//  res_o    out  kind, tx_frame, last          valid && ready
//  cfg_i    in   idx, data                     valid && ready (always ready)
//
//  The sequencer visits one window slot per cycle through the single slot
//  access port, unless the result output stalls it. An event is taken
//  only in the idle state, so the next one waits until the sequencer
//  has finished with the last.
//  Reset is asynchronous; no clearing pass, start clears the window slots.
//  A stalled result output holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
  parameter int WINDOW     = srsw_pkg::WINDOW_DEF,
  parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srsw_evt_if.sink  evt_i,
  srsw_res_if.source res_o,
  srsw_cfg_if.sink  cfg_i
);
  import srsw_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [SW-1:0]      SLOT_LAST = SW'(WINDOW - 1);
  localparam logic [CW-1:0]      CNT_WIN   = CW'(WINDOW);
  localparam logic [FRAME_W:0]   WIN_EXT   = (FRAME_W + 1)'(WINDOW);
  localparam logic [SW:0]        WIN_SUM   = (SW + 1)'(WINDOW);
  localparam logic [RETRY_W-1:0] RETRY_SAT = '1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_DONE  = 2'd2,
    PH_ABORT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_TICK,
    S_ACK,
    S_SLIDE,
    S_FLUSH
  } state_e;

  cfg_t cfg;

  srsw_cfg #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic [FRAME_W-1:0]     base_q, base_d;
  logic [SW-1:0]          bslot_q, bslot_d;
  logic [FRAME_W-1:0]     cur_q, cur_d;
  logic [SW-1:0]          cslot_q, cslot_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   abort_q, abort_d;
  logic [FRAME_NUM_W-1:0] af_q, af_d;

  logic                   acked_q [WINDOW];
  logic                   acked_d [WINDOW];
  logic [RETRY_W-1:0]     retry_q [WINDOW];
  logic [RETRY_W-1:0]     retry_d [WINDOW];
  logic [TIMER_W-1:0]     timer_q [WINDOW];
  logic [TIMER_W-1:0]     timer_d [WINDOW];

  logic                   hold_v_q, hold_v_d;
  kind_e                  hold_kind_q, hold_kind_d;
  logic [FRAME_NUM_W-1:0] hold_frame_q, hold_frame_d;
  logic                   out_v_q, out_v_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [FRAME_NUM_W-1:0] out_frame_q, out_frame_d;
  logic                   out_last_q, out_last_d;

  logic                   evt_acc;
  logic                   out_free;
  logic                   emit_ok;
  logic                   emit;
  kind_e                  emit_kind;
  logic [FRAME_NUM_W-1:0] emit_frame;
  logic                   flush;

  logic [FRAME_W-1:0]     fc;
  logic [FRAME_W-1:0]     af_ext;
  logic [FRAME_W-1:0]     off;
  logic [SW:0]            slot_sum;
  logic [SW-1:0]          ack_slot;
  logic                   ack_hit;
  logic [SW-1:0]          sidx;
  logic                   scan_more;
  logic [SW-1:0]          cslot_inc;
  logic [SW-1:0]          bslot_inc;
  logic [FRAME_W:0]       nf;
  logic [RETRY_W-1:0]     retry_new;

  assign fc       = cfg.live_count;
  assign evt_acc  = evt_i.valid && evt_i.ready;
  assign out_free = !out_v_q || res_o.ready;
  assign emit_ok  = !hold_v_q || out_free;

  // ack slot: base slot plus offset into the window, one wrap at most
  assign af_ext   = FRAME_W'(af_q);
  assign off      = af_ext - base_q;
  assign slot_sum = {1'b0, bslot_q} + off[SW:0];
  assign ack_slot = (slot_sum >= WIN_SUM) ? SW'(slot_sum - WIN_SUM) : slot_sum[SW-1:0];

  assign cslot_inc = (cslot_q == SLOT_LAST) ? '0 : cslot_q + SW'(1);
  assign bslot_inc = (bslot_q == SLOT_LAST) ? '0 : bslot_q + SW'(1);
  assign scan_more = (cnt_q < CNT_WIN) && (cur_q < fc);
  assign nf        = {1'b0, base_q} + WIN_EXT;

  always_comb begin
    unique case (state_q)
      S_ACK:   sidx = ack_slot;
      S_SLIDE: sidx = bslot_q;
      default: sidx = cslot_q;
    endcase
  end

  assign ack_hit   = (af_ext >= base_q) && (off < FRAME_W'(WINDOW)) && (af_ext < fc) &&
                     !acked_q[sidx];
  assign retry_new = (retry_q[sidx] == RETRY_SAT) ? RETRY_SAT : retry_q[sidx] + RETRY_W'(1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    base_d     = base_q;
    bslot_d    = bslot_q;
    cur_d      = cur_q;
    cslot_d    = cslot_q;
    cnt_d      = cnt_q;
    abort_d    = abort_q;
    af_d       = af_q;
    acked_d    = acked_q;
    retry_d    = retry_q;
    timer_d    = timer_q;
    emit       = 1'b0;
    emit_kind  = K_SEND;
    emit_frame = '0;
    flush      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (evt_acc) begin
          cur_d   = '0;
          cslot_d = '0;
          cnt_d   = '0;
          abort_d = 1'b0;
          af_d    = evt_i.ack_frame;
          unique case (evt_i.cmd)
            CMD_START: begin
              acked_d = '{default: 1'b0};
              retry_d = '{default: '0};
              timer_d = '{default: '0};
              base_d  = '0;
              bslot_d = '0;
              if (fc == '0) begin
                phase_d   = PH_DONE;
                emit      = 1'b1;
                emit_kind = K_DONE;
                state_d   = S_FLUSH;
              end else begin
                phase_d = PH_RUN;
                state_d = S_START;
              end
            end
            CMD_TICK, CMD_ACK: begin
              if (phase_q == PH_RUN) begin
                if (base_q >= fc) begin
                  phase_d   = PH_DONE;
                  emit      = 1'b1;
                  emit_kind = K_DONE;
                  state_d   = S_FLUSH;
                end else if (evt_i.cmd == CMD_TICK) begin
                  cur_d   = base_q;
                  cslot_d = bslot_q;
                  state_d = S_TICK;
                end else begin
                  state_d = S_ACK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_START: begin
        if (scan_more) begin
          if (emit_ok) begin
            timer_d[sidx] = cfg.reload;
            emit          = 1'b1;
            emit_kind     = K_SEND;
            emit_frame    = cur_q[FRAME_NUM_W-1:0];
            cur_d         = cur_q + FRAME_W'(1);
            cslot_d       = cslot_inc;
            cnt_d         = cnt_q + CW'(1);
          end
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_TICK: begin
        if (scan_more) begin
          if (acked_q[sidx]) begin
            cur_d   = cur_q + FRAME_W'(1);
            cslot_d = cslot_inc;
            cnt_d   = cnt_q + CW'(1);
          end else if (timer_q[sidx] <= TIMER_W'(1)) begin
            if (emit_ok) begin
              retry_d[sidx] = retry_new;
              timer_d[sidx] = cfg.reload;
              emit          = 1'b1;
              emit_kind     = K_RESEND;
              emit_frame    = cur_q[FRAME_NUM_W-1:0];
              if (retry_new >= cfg.retry_limit) abort_d = 1'b1;
              cur_d   = cur_q + FRAME_W'(1);
              cslot_d = cslot_inc;
              cnt_d   = cnt_q + CW'(1);
            end
          end else begin
            timer_d[sidx] = timer_q[sidx] - TIMER_W'(1);
            cur_d   = cur_q + FRAME_W'(1);
            cslot_d = cslot_inc;
            cnt_d   = cnt_q + CW'(1);
          end
        end else if (abort_q) begin
          if (emit_ok) begin
            phase_d   = PH_ABORT;
            emit      = 1'b1;
            emit_kind = K_ABORT;
            state_d   = S_FLUSH;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_ACK: begin
        if (ack_hit) begin
          acked_d[sidx] = 1'b1;
          state_d       = S_SLIDE;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_SLIDE: begin
        if ((base_q < fc) && acked_q[sidx]) begin
          // slide past one acked frame and admit the frame a window ahead
          if (!(nf < {1'b0, fc}) || emit_ok) begin
            acked_d[sidx] = 1'b0;
            retry_d[sidx] = '0;
            timer_d[sidx] = cfg.reload;
            base_d        = base_q + FRAME_W'(1);
            bslot_d       = bslot_inc;
            if (nf < {1'b0, fc}) begin
              emit       = 1'b1;
              emit_kind  = K_SEND;
              emit_frame = nf[FRAME_NUM_W-1:0];
            end
          end
        end else if (base_q >= fc) begin
          if (emit_ok) begin
            phase_d   = PH_DONE;
            emit      = 1'b1;
            emit_kind = K_DONE;
            state_d   = S_FLUSH;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // result staging: the newest result waits in hold until the next one or
  // the end of the event shows whether it is the last
  always_comb begin
    hold_v_d     = hold_v_q;
    hold_kind_d  = hold_kind_q;
    hold_frame_d = hold_frame_q;
    out_v_d      = out_v_q && !res_o.ready;
    out_kind_d   = out_kind_q;
    out_frame_d  = out_frame_q;
    out_last_d   = out_last_q;
    if (emit) begin
      if (hold_v_q) begin
        out_v_d     = 1'b1;
        out_kind_d  = hold_kind_q;
        out_frame_d = hold_frame_q;
        out_last_d  = 1'b0;
      end
      hold_v_d     = 1'b1;
      hold_kind_d  = emit_kind;
      hold_frame_d = emit_frame;
    end else if (flush) begin
      out_v_d     = 1'b1;
      out_kind_d  = hold_kind_q;
      out_frame_d = hold_frame_q;
      out_last_d  = 1'b1;
      hold_v_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_IDLE;
      base_q   <= '0;
      bslot_q  <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      base_q   <= base_d;
      bslot_q  <= bslot_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    cslot_q      <= cslot_d;
    cnt_q        <= cnt_d;
    abort_q      <= abort_d;
    af_q         <= af_d;
    acked_q      <= acked_d;
    retry_q      <= retry_d;
    timer_q      <= timer_d;
    hold_kind_q  <= hold_kind_d;
    hold_frame_q <= hold_frame_d;
    out_kind_q   <= out_kind_d;
    out_frame_q  <= out_frame_d;
    out_last_q   <= out_last_d;
  end

  assign evt_i.ready    = (state_q == S_IDLE);
  assign res_o.valid    = out_v_q;
  assign res_o.kind     = out_kind_q;
  assign res_o.tx_frame = out_frame_q;
  assign res_o.last     = out_last_q;

  // no result is left waiting in hold while the sequencer is idle
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q)
    else $error("pending result left in hold while idle");

  a_bslot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bslot_q <= SLOT_LAST)
    else $error("base slot out of window");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_START) |-> (cnt_q <= CNT_WIN))
    else $error("window scan ran past the window");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_acc && evt_i.cmd == CMD_START) |=> (phase_q != PH_IDLE))
    else $error("start did not open a transfer");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> (out_v_q && out_last_q))
    else $error("final result not presented with last set");

endmodule

/* sim/tb_selective_repeat_sender_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window_unit: self-checking bench of the ARQ sender
// Drives start, tick and ack events plus register writes. A scoreboard class
// predicts each send, resend, complete and abort transaction and compares
// it with the result channel, while both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window_unit;
  import srsw_pkg::*;

  localparam int WINDOW         = WINDOW_DEF;
  localparam int MAX_FRAMES     = MAX_FRAMES_DEF;
  localparam int RANDOM_EVENTS  = 470;
  localparam int QUIET_FROM     = 400;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RETRY_CEIL     = 15;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_DONE  = 2'd2,
    PH_ABORT = 2'd3
  } xfer_phase_e;

  typedef struct packed {
    kind_e                  kind;
    logic [FRAME_NUM_W-1:0] frame;
    logic                   last;
  } arq_result_t;

  class arq_sender_scoreboard;
    logic [TIMER_W-1:0] timeout;
    logic [RETRY_W-1:0] retry_limit;
    logic [FRAME_W-1:0] frame_total;

    int unsigned base;
    bit          acked[WINDOW];
    int unsigned retries[WINDOW];
    int unsigned timer[WINDOW];
    xfer_phase_e phase;

    arq_result_t event_results[$];
    arq_result_t due_results[$];
    int          errors;

    function new();
      timeout     = TIMEOUT_RST;
      retry_limit = RETRY_LIMIT_RST;
      frame_total = FRAME_COUNT_RST;
      base        = 0;
      phase       = PH_IDLE;
      errors      = 0;
      clear_slots();
    endfunction

    function void clear_slots();
      for (int s = 0; s < WINDOW; s++) begin
        acked[s]   = 1'b0;
        retries[s] = 0;
        timer[s]   = 0;
      end
    endfunction

    function int unsigned live_total();
      return (frame_total > MAX_FRAMES) ? MAX_FRAMES : frame_total;
    endfunction

    function int unsigned reload_value();
      return (timeout == 0) ? 1 : timeout;
    endfunction

    function void add(kind_e kind, int unsigned frame);
      arq_result_t r;
      r.kind  = kind;
      r.frame = frame[FRAME_NUM_W-1:0];
      r.last  = 1'b0;
      event_results.push_back(r);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT:     timeout = data;
        CFG_RETRY_LIMIT: retry_limit = data[RETRY_W-1:0];
        CFG_FRAME_COUNT: frame_total = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    // Note an accepted event; return 1 when it changes state or yields results.
    function bit take_event(logic [CMD_W-1:0] cmd, logic [FRAME_NUM_W-1:0] ack_frame);
      int unsigned fc;
      int unsigned af;
      int unsigned s;
      int unsigned b;
      int unsigned nf;
      bit          acted;
      bit          abort;
      arq_result_t r;
      fc    = live_total();
      af    = 32'(ack_frame);
      acted = 1'b0;
      abort = 1'b0;
      event_results.delete();
      if (cmd == CMD_START) begin
        acted = 1'b1;
        clear_slots();
        base = 0;
        if (fc == 0) begin
          phase = PH_DONE;
          add(K_DONE, 0);
        end else begin
          phase = PH_RUN;
          for (int unsigned f = 0; f < WINDOW && f < fc; f++) begin
            timer[f % WINDOW] = reload_value();
            add(K_SEND, f);
          end
        end
      end else if ((cmd == CMD_TICK || cmd == CMD_ACK) && phase == PH_RUN) begin
        if (base >= fc) begin
          acted = 1'b1;
          phase = PH_DONE;
          add(K_DONE, 0);
        end else if (cmd == CMD_TICK) begin
          acted = 1'b1;
          for (int unsigned f = base; f < base + WINDOW && f < fc; f++) begin
            s = f % WINDOW;
            if (acked[s]) continue;
            if (timer[s] <= 1) begin
              if (retries[s] < RETRY_CEIL) retries[s]++;
              timer[s] = reload_value();
              add(K_RESEND, f);
              if (retries[s] >= retry_limit) abort = 1'b1;
            end else begin
              timer[s]--;
            end
          end
          if (abort) begin
            phase = PH_ABORT;
            add(K_ABORT, 0);
          end
        end else begin
          s = af % WINDOW;
          if (af >= base && af < base + WINDOW && af < fc && !acked[s]) begin
            acted    = 1'b1;
            acked[s] = 1'b1;
            // slide the base over every acked frame, admitting new ones
            while (base < fc && acked[base % WINDOW]) begin
              b          = base % WINDOW;
              nf         = base + WINDOW;
              acked[b]   = 1'b0;
              retries[b] = 0;
              timer[b]   = reload_value();
              base++;
              if (nf < fc) add(K_SEND, nf);
            end
            if (base >= fc) begin
              phase = PH_DONE;
              add(K_DONE, 0);
            end
          end
        end
      end
      if (event_results.size() > 0) begin
        r      = event_results.pop_back();
        r.last = 1'b1;
        event_results.push_back(r);
      end
      foreach (event_results[i]) due_results.push_back(event_results[i]);
      return acted;
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [FRAME_NUM_W-1:0] frame,
                               logic last);
      arq_result_t exp_r;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d tx_frame %0d last %0d", kind, frame, last);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
        errors++;
      end
      if (frame !== exp_r.frame) begin
        $error("tx_frame: expected %0d, actual %0d", exp_r.frame, frame);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("last: expected %0d, actual %0d", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  srsw_evt_if evt ();
  srsw_res_if res ();
  srsw_cfg_if cfg ();

  selective_repeat_sender_window_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  arq_sender_scoreboard sb;
  bit quiet;
  int sent_events;
  int idle_cycles;

  initial begin
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    quiet         = 1'b0;
    sent_events   = 0;
    evt.valid     = 1'b0;
    evt.cmd       = CMD_START;
    evt.ack_frame = '0;
    cfg.valid     = 1'b0;
    cfg.idx       = CFG_TIMEOUT;
    cfg.data      = '0;
    res.ready     = 1'b1;
  end

  always #5 clk_i = ~clk_i;

  // Result side: random stall bursts, no new ones once the run goes quiet.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (quiet) begin
        res.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        hold = $urandom_range(1, 13) - 1;
      end else begin
        res.ready <= 1'b1;
        hold = $urandom_range(0, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      sb.check_result(res.kind, res.tx_frame, res.last);
  end

  always @(posedge clk_i) begin
    if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[selective_repeat_sender_window_unit] ERROR");
      $finish;
    end
  end

  initial idle_cycles = 0;

  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [FRAME_NUM_W-1:0] frame);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid     <= 1'b1;
    evt.cmd       <= cmd;
    evt.ack_frame <= frame;
    do @(posedge clk_i); while (!evt.ready);
    void'(sb.take_event(cmd, frame));
    sent_events++;
  endtask

  // Drop the event valid and let the block drain before a register write.
  task automatic settle();
    evt.valid <= 1'b0;
    while (sb.due_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.idx   <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] timeout,
                           input logic [CFG_DATA_W-1:0] retry_limit,
                           input logic [CFG_DATA_W-1:0] frames);
    settle();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_RETRY_LIMIT, retry_limit);
    write_reg(CFG_FRAME_COUNT, frames);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_transfer();
    int unsigned timeout;
    int unsigned retry_limit;
    int unsigned frames;
    int unsigned cap;
    int unsigned pick;
    int unsigned tail;
    int unsigned open_frames[$];
    case ($urandom_range(0, 9))
      0:       timeout = 0;
      1:       timeout = 1;
      2:       timeout = 16'hFFFF;
      3:       timeout = $urandom_range(0, 16'hFFFF);
      default: timeout = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 7))
      0:       retry_limit = 0;
      1:       retry_limit = RETRY_CEIL;
      2:       retry_limit = $urandom_range(0, RETRY_CEIL);
      default: retry_limit = $urandom_range(1, 5);
    endcase
    case ($urandom_range(0, 11))
      0:       frames = 0;
      1:       frames = MAX_FRAMES;
      2:       frames = 2047;
      3:       frames = $urandom_range(0, 2047);
      default: frames = $urandom_range(1, 12);
    endcase
    configure(CFG_DATA_W'(timeout), CFG_DATA_W'(retry_limit), CFG_DATA_W'(frames));
    send_event(CMD_START, FRAME_NUM_W'($urandom_range(0, 1023)));
    cap  = (sb.live_total() > 16) ? 40 : 80;
    tail = $urandom_range(0, 2);
    for (int unsigned step = 0; step < cap; step++) begin
      if (sent_events >= RANDOM_EVENTS) break;
      if (sb.phase != PH_RUN) begin
        if (tail == 0) break;
        tail--;
      end
      if (sb.phase == PH_RUN && $urandom_range(0, 99) < 4) begin
        // change the frame count under a running transfer
        settle();
        write_reg(CFG_FRAME_COUNT, CFG_DATA_W'($urandom_range(0, sb.base + 6)));
        cfg.valid <= 1'b0;
      end
      open_frames.delete();
      for (int unsigned f = sb.base; f < sb.base + WINDOW && f < sb.live_total(); f++)
        if (!sb.acked[f % WINDOW]) open_frames.push_back(f);
      pick = $urandom_range(0, 99);
      if (pick < 8 || sb.phase != PH_RUN)
        send_event(CMD_W'($urandom_range(0, 3)), FRAME_NUM_W'($urandom_range(0, 1023)));
      else if (pick < 32 || open_frames.size() == 0)
        send_event(CMD_TICK, FRAME_NUM_W'($urandom_range(0, 1023)));
      else
        send_event(CMD_ACK,
                   FRAME_NUM_W'(open_frames[$urandom_range(0, open_frames.size() - 1)]));
      if (sent_events >= QUIET_FROM) quiet = 1'b1;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one frame, ignored events around it.
    send_event(CMD_TICK, 0);
    send_event(CMD_ACK, 5);
    send_event(CMD_UNUSED, 1023);
    send_event(CMD_START, 0);
    send_event(CMD_ACK, 1);
    send_event(CMD_ACK, 0);
    send_event(CMD_TICK, 0);

    // Zero frames completes at once.
    configure(2000, 3, 0);
    send_event(CMD_START, 0);

    // Zero timeout and zero retry limit: first tick resends and aborts.
    configure(0, 0, 6);
    send_event(CMD_START, 0);
    send_event(CMD_TICK, 0);

    // Out-of-order acks, slide, duplicate ack, restart while running.
    configure(1, 2, 6);
    send_event(CMD_START, 0);
    send_event(CMD_ACK, 2);
    send_event(CMD_ACK, 0);
    send_event(CMD_ACK, 0);
    send_event(CMD_ACK, 1);
    send_event(CMD_TICK, 0);
    send_event(CMD_START, 0);
    send_event(CMD_TICK, 0);
    send_event(CMD_TICK, 0);

    // Oversized frame count saturates.
    configure(16'hFFFF, CFG_DATA_W'(RETRY_CEIL), 2047);
    send_event(CMD_START, 0);
    send_event(CMD_ACK, 1023);
    send_event(CMD_ACK, 3);

    while (sent_events < RANDOM_EVENTS) run_transfer();

    evt.valid <= 1'b0;
    while (sb.due_results.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("[selective_repeat_sender_window_unit] OK");
    else
      $display("[selective_repeat_sender_window_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/srsw_pkg.sv
rtl/srsw_ifs.sv
rtl/srsw_cfg.sv
rtl/selective_repeat_sender_window_unit.sv
sim/tb_selective_repeat_sender_window_unit.sv
